>>> rtl/core/tdfs_pkg.sv
// ----------------------------------------------------------------------------
// tdfs_pkg
// Shared widths, result codes and controller/datapath handshake types for the
// timer prescaler and period search.
// ----------------------------------------------------------------------------
package tdfs_pkg;

    localparam int HZ_W  = 32;
    localparam int PSC_W = 16;
    localparam int PER_W = 16;
    localparam int ST_W  = 2;
    localparam int DIV_W = HZ_W + 2;

    localparam logic [HZ_W-1:0] CLK_RESET = 32'd120000000;

    typedef enum logic [ST_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_ZERO_RATE = 2'd1,
        ST_NO_FACTOR = 2'd2
    } t_status;

    typedef struct packed {
        logic    cap_rate;
        logic    go_count;
        logic    go_trial;
        logic    go_actual;
        logic    save_count;
        logic    clr_p;
        logic    inc_p;
        logic    save_q;
        logic    set_res;
        t_status res_st;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic rate_zero;
        logic past_count;
        logic too_big;
        logic exact;
        logic p_last;
    } t_sts;

endpackage

>>> rtl/core/tdfs_cfg_if.sv
// ----------------------------------------------------------------------------
// tdfs_cfg_if
// Configuration write channel: system clock frequency in hertz.
// ----------------------------------------------------------------------------
interface tdfs_cfg_if;
    import tdfs_pkg::*;

    logic            valid;
    logic            ready;
    logic [HZ_W-1:0] sys_clock_hz;

    modport source (output valid, output sys_clock_hz, input ready);
    modport sink   (input valid, input sys_clock_hz, output ready);
endinterface

>>> rtl/core/tdfs_req_if.sv
// ----------------------------------------------------------------------------
// tdfs_req_if
// Request channel: one item carries the wanted sample rate in hertz.
// ----------------------------------------------------------------------------
interface tdfs_req_if;
    import tdfs_pkg::*;

    logic            valid;
    logic            ready;
    logic [HZ_W-1:0] desired_hz;

    modport source (output valid, output desired_hz, input ready);
    modport sink   (input valid, input desired_hz, output ready);
endinterface

>>> rtl/core/tdfs_rsp_if.sv
// ----------------------------------------------------------------------------
// tdfs_rsp_if
// Result channel: status, prescale, period and achieved rate.
// ----------------------------------------------------------------------------
interface tdfs_rsp_if;
    import tdfs_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [PSC_W-1:0] prescale;
    logic [PER_W-1:0] period;
    logic [HZ_W-1:0]  actual_hz;

    modport source (output valid, output status, output prescale, output period,
                    output actual_hz, input ready);
    modport sink   (input valid, input status, input prescale, input period,
                    input actual_hz, output ready);
endinterface

>>> rtl/core/tdfs_div.sv
// ----------------------------------------------------------------------------
// tdfs_div
// Bit-serial restoring divider, one quotient bit per cycle. Full mode runs
// DIV_W steps; short mode runs SHORT_STEPS steps and requires the quotient to
// fit in SHORT_STEPS bits.
// ----------------------------------------------------------------------------
module tdfs_div #(
    parameter int SHORT_STEPS = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_short,
    input  logic [tdfs_pkg::DIV_W-1:0] i_dividend,
    input  logic [tdfs_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [tdfs_pkg::DIV_W-1:0] o_quo,
    output logic [tdfs_pkg::DIV_W-1:0] o_rem
);
    import tdfs_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W-1:0] rem_shift;
    logic             fits;

    always_comb begin
        rem_shift = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
        fits      = rem_shift >= r_dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_short ? CW'(SHORT_STEPS) : CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            if (i_short) begin
                r_rem <= i_dividend >> SHORT_STEPS;
                r_quo <= i_dividend << (DIV_W - SHORT_STEPS);
            end else begin
                r_rem <= '0;
                r_quo <= i_dividend;
            end
        end else if (r_busy) begin
            r_rem <= fits ? (rem_shift - r_dvs) : rem_shift;
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/tdfs_dpath.sv
// ----------------------------------------------------------------------------
// tdfs_dpath
// Datapath: clock register, rounded count, prescale counter, trial checks,
// shared serial divider, result staging and output registers.
// ----------------------------------------------------------------------------
module tdfs_dpath #(
    parameter int PRESCALE_LIMIT   = 65535,
    parameter int PERIOD_COUNT_MAX = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tdfs_cfg_if.sink                   i_cfg,
    input  logic [tdfs_pkg::HZ_W-1:0]  i_desired_hz,
    input  tdfs_pkg::t_cmd             i_cmd,
    output tdfs_pkg::t_sts             o_sts,
    output logic [tdfs_pkg::ST_W-1:0]  o_status,
    output logic [tdfs_pkg::PSC_W-1:0] o_prescale,
    output logic [tdfs_pkg::PER_W-1:0] o_period,
    output logic [tdfs_pkg::HZ_W-1:0]  o_actual_hz
);
    import tdfs_pkg::*;

    localparam int QW    = $clog2(PERIOD_COUNT_MAX + 1);
    localparam int PRD_W = HZ_W + 1;
    localparam int DV_W  = PSC_W + 1;
    localparam logic [PRD_W-1:0] QCAP   = PRD_W'(PERIOD_COUNT_MAX + 1);
    localparam logic [PSC_W-1:0] P_LAST = PSC_W'(PRESCALE_LIMIT - 1);

    logic [HZ_W-1:0]  r_clk;
    logic [HZ_W-1:0]  r_rate;
    logic [HZ_W-1:0]  r_count;
    logic [PSC_W-1:0] r_p;
    logic [QW-1:0]    r_q;
    t_status          r_res_st;
    logic [PSC_W-1:0] r_res_psc;
    logic [PER_W-1:0] r_res_per;
    logic [HZ_W-1:0]  r_res_act;
    t_status          r_o_st;
    logic [PSC_W-1:0] r_o_psc;
    logic [PER_W-1:0] r_o_per;
    logic [HZ_W-1:0]  r_o_act;

    logic [DV_W-1:0]  div_val;
    logic [PRD_W-1:0] lim_prod;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk <= CLK_RESET;
        end else if (i_cfg.valid) begin
            r_clk <= i_cfg.sys_clock_hz;
        end
    end

    always_comb begin
        div_val   = {1'b0, r_p} + DV_W'(1);
        lim_prod  = PRD_W'(PRD_W'(div_val) * QCAP);
        div_start = i_cmd.go_count | i_cmd.go_trial | i_cmd.go_actual;
        if (i_cmd.go_count) begin
            div_dividend = DIV_W'({r_clk, 1'b0}) + DIV_W'(r_rate);
            div_divisor  = DIV_W'({r_rate, 1'b0});
        end else if (i_cmd.go_trial) begin
            div_dividend = DIV_W'(r_count);
            div_divisor  = DIV_W'(div_val);
        end else begin
            div_dividend = DIV_W'(r_clk);
            div_divisor  = DIV_W'(r_count);
        end
    end

    tdfs_div #(
        .SHORT_STEPS (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_short    (i_cmd.go_trial),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        o_sts.div_done   = div_done;
        o_sts.rate_zero  = r_rate == '0;
        o_sts.past_count = HZ_W'(div_val) > r_count;
        o_sts.too_big    = PRD_W'(r_count) >= lim_prod;
        o_sts.exact      = div_rem == '0;
        o_sts.p_last     = r_p == P_LAST;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_rate) begin
            r_rate <= i_desired_hz;
        end
        if (i_cmd.save_count) begin
            r_count <= div_quo[HZ_W-1:0];
        end
        if (i_cmd.clr_p) begin
            r_p <= '0;
        end else if (i_cmd.inc_p) begin
            r_p <= r_p + PSC_W'(1);
        end
        if (i_cmd.save_q) begin
            r_q <= div_quo[QW-1:0];
        end
        if (i_cmd.set_res) begin
            r_res_st <= i_cmd.res_st;
            if (i_cmd.res_st == ST_FOUND) begin
                r_res_psc <= r_p;
                r_res_per <= PER_W'(r_q - QW'(1));
                r_res_act <= div_quo[HZ_W-1:0];
            end else begin
                r_res_psc <= '0;
                r_res_per <= '0;
                r_res_act <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_o_st  <= r_res_st;
            r_o_psc <= r_res_psc;
            r_o_per <= r_res_per;
            r_o_act <= r_res_act;
        end
    end

    assign o_status    = r_o_st;
    assign o_prescale  = r_o_psc;
    assign o_period    = r_o_per;
    assign o_actual_hz = r_o_act;

endmodule

>>> rtl/core/tdfs_ctrl.sv
// ----------------------------------------------------------------------------
// tdfs_ctrl
// Controller: sequences the count division, the prescale search and the
// achieved-rate division, and owns the request/result handshakes.
// ----------------------------------------------------------------------------
module tdfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  tdfs_pkg::t_sts i_sts,
    output tdfs_pkg::t_cmd o_cmd
);
    import tdfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZCHK,
        S_COUNT,
        S_CHECK,
        S_TRIAL,
        S_ACTUAL,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.res_st = ST_NO_FACTOR;
        o_req_ready = r_state == S_IDLE;
        n_out_valid = r_out_valid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.cap_rate = 1'b1;
                    n_state        = S_ZCHK;
                end
            end
            S_ZCHK: begin
                if (i_sts.rate_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_ZERO_RATE;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.go_count = 1'b1;
                    n_state        = S_COUNT;
                end
            end
            S_COUNT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_count = 1'b1;
                    o_cmd.clr_p      = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.past_count) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_FIN;
                end else if (i_sts.too_big) begin
                    if (i_sts.p_last) begin
                        o_cmd.set_res = 1'b1;
                        n_state       = S_FIN;
                    end else begin
                        o_cmd.inc_p = 1'b1;
                    end
                end else begin
                    o_cmd.go_trial = 1'b1;
                    n_state        = S_TRIAL;
                end
            end
            S_TRIAL: begin
                if (i_sts.div_done) begin
                    if (i_sts.exact) begin
                        o_cmd.save_q    = 1'b1;
                        o_cmd.go_actual = 1'b1;
                        n_state         = S_ACTUAL;
                    end else if (i_sts.p_last) begin
                        o_cmd.set_res = 1'b1;
                        n_state       = S_FIN;
                    end else begin
                        o_cmd.inc_p = 1'b1;
                        n_state     = S_CHECK;
                    end
                end
            end
            S_ACTUAL: begin
                if (i_sts.div_done) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_FOUND;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

>>> rtl/core/timer_divider_factor_search.sv
// ----------------------------------------------------------------------------
// timer_divider_factor_search
// Finds a prescale and period whose factors (each field plus one) give the
// rounded clock count for a requested sample rate; reports the achieved rate.
// ----------------------------------------------------------------------------
// One request is processed at a time; a finished result waits in the output
// register while the next request is taken. All divisions run on one shared
// bit-serial divider (one quotient bit per cycle). A zero rate is answered
// without any division. Otherwise the rounded count is divided out first,
// then each prescale is tried in turn: one whose period would overflow is
// skipped without a division, any other gets a short trial division; a
// match adds a full division for the achieved rate. The worst case is a
// search over all 65535 prescale values.
module timer_divider_factor_search #(
    parameter int PRESCALE_LIMIT   = 65535,
    parameter int PERIOD_COUNT_MAX = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdfs_cfg_if.sink   i_cfg,
    tdfs_req_if.sink   i_req,
    tdfs_rsp_if.source o_rsp
);
    import tdfs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tdfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tdfs_dpath #(
        .PRESCALE_LIMIT   (PRESCALE_LIMIT),
        .PERIOD_COUNT_MAX (PERIOD_COUNT_MAX)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_desired_hz (i_req.desired_hz),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_status     (o_rsp.status),
        .o_prescale   (o_rsp.prescale),
        .o_period     (o_rsp.period),
        .o_actual_hz  (o_rsp.actual_hz)
    );

endmodule

>>> rtl/core/tdfs_chk.sv
// ----------------------------------------------------------------------------
// tdfs_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tdfs_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [tdfs_pkg::ST_W-1:0]  i_status,
    input logic [tdfs_pkg::PSC_W-1:0] i_prescale,
    input logic [tdfs_pkg::PER_W-1:0] i_period,
    input logic [tdfs_pkg::HZ_W-1:0]  i_actual_hz
);
    import tdfs_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == ST_FOUND || i_status == ST_ZERO_RATE ||
                         i_status == ST_NO_FACTOR))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_FOUND |->
            i_prescale == '0 && i_period == '0 && i_actual_hz == '0)
        else $error("failed result carries nonzero fields");

    a_found_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_FOUND |-> i_actual_hz != '0)
        else $error("found result with zero achieved rate");

endmodule

bind timer_divider_factor_search tdfs_chk u_tdfs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_prescale  (o_rsp.prescale),
    .i_period    (o_rsp.period),
    .i_actual_hz (o_rsp.actual_hz)
);
